>>> rtl/core/binary_gcd_unit_macros.svh
// assertion macros for the binary gcd unit
// expects signals named clk and rst in the scope of use
`ifndef BINARY_GCD_UNIT_MACROS_SVH
`define BINARY_GCD_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BGCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bgcd: assertion failed");

// next-cycle implication, disabled during reset
`define BGCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bgcd: assertion failed");

`endif

>>> rtl/core/bgcd_pkg.sv
// shared types and constants for the binary gcd unit
// no dependencies
package bgcd_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int TWOS_W     = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STRIP,
    ST_ODDX,
    ST_LOOP,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic strip;
    logic shift_x;
    logic shift_y;
    logic sub_step;
    logic store_result;
  } gcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_lsb;
    logic y_lsb;
    logic x_eq_y;
  } gcd_status_t;

endpackage

>>> rtl/core/bgcd_dpath.sv
// datapath of the binary gcd unit: operand, count and result registers
// depends on bgcd_pkg
module bgcd_dpath (
  input  logic                             clk,
  input  bgcd_pkg::gcd_cmd_t               cmd,
  input  logic [bgcd_pkg::DATA_WIDTH-1:0]  operand_a,
  input  logic [bgcd_pkg::DATA_WIDTH-1:0]  operand_b,
  output bgcd_pkg::gcd_status_t            status,
  output logic [bgcd_pkg::DATA_WIDTH-1:0]  gcd_value
);
  import bgcd_pkg::*;

  logic [DATA_WIDTH-1:0] x;
  logic [DATA_WIDTH-1:0] y;
  logic [TWOS_W-1:0]     twos;
  logic [DATA_WIDTH-1:0] result;
  logic                  x_gt_y;
  logic [DATA_WIDTH-1:0] diff_xy;
  logic [DATA_WIDTH-1:0] diff_yx;

  // compare and both differences for the subtract step
  assign x_gt_y  = x > y;
  assign diff_xy = x - y;
  assign diff_yx = y - x;

  // status back to the controller
  assign status.x_zero = (x == '0);
  assign status.y_zero = (y == '0);
  assign status.x_lsb  = x[0];
  assign status.y_lsb  = y[0];
  assign status.x_eq_y = (x == y);

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= operand_a;
      y    <= operand_b;
      twos <= '0;
    end else if (cmd.strip) begin
      x    <= x >> 1;
      y    <= y >> 1;
      twos <= twos + TWOS_W'(1);
    end else if (cmd.shift_x) begin
      x <= x >> 1;
    end else if (cmd.shift_y) begin
      y <= y >> 1;
    end else if (cmd.sub_step) begin
      if (x_gt_y) begin
        x <= y;
        y <= diff_xy;
      end else begin
        y <= diff_yx;
      end
    end
  end

  // output register: y is zero in the normal path, twos is zero when an operand is zero
  always_ff @(posedge clk) begin
    if (cmd.store_result) begin
      result <= (x << twos) | y;
    end
  end

  assign gcd_value = result;

endmodule

>>> rtl/core/bgcd_ctrl.sv
// controller of the binary gcd unit: sequencing state machine and output valid
// depends on bgcd_pkg
module bgcd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  bgcd_pkg::gcd_status_t  status,
  output bgcd_pkg::gcd_cmd_t     cmd
);
  import bgcd_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.x_zero || status.y_zero) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (!status.x_lsb && !status.y_lsb) begin
          cmd.strip = 1'b1;
        end else begin
          state_next = ST_ODDX;
        end
      end
      ST_ODDX: begin
        if (!status.x_lsb) begin
          cmd.shift_x = 1'b1;
        end else begin
          state_next = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (!status.y_lsb) begin
          cmd.shift_y = 1'b1;
        end else begin
          cmd.sub_step = 1'b1;
          if (status.x_eq_y) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.store_result = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.store_result) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/core/binary_gcd_unit.sv
// top level of the binary gcd unit: controller plus datapath
// depends on bgcd_pkg, bgcd_ctrl, bgcd_dpath and binary_gcd_unit_macros.svh
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------
//   input   | in_valid / in_ready    | operand_a, operand_b
//   output  | out_valid / out_ready  | gcd_value
//
// one item in flight; a beat is taken only in the idle state
// the time per item grows with the number of shift and subtract steps in the datapath loop;
//   the loop is bounded, as each shift halves x*y and a shift follows each subtract
// zero operands bypass the loop: the check state goes straight to the finish state
// the result sits in an output register, so the next beat is taken while it waits
// reset is synchronous and clears only the controller state and output valid
`include "binary_gcd_unit_macros.svh"

module binary_gcd_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bgcd_pkg::DATA_WIDTH-1:0]  operand_a,
  input  logic [bgcd_pkg::DATA_WIDTH-1:0]  operand_b,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bgcd_pkg::DATA_WIDTH-1:0]  gcd_value
);
  import bgcd_pkg::*;

  gcd_cmd_t    cmd;
  gcd_status_t status;

  // sequencing
  bgcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // registers and arithmetic
  bgcd_dpath u_dpath (
    .clk       (clk),
    .cmd       (cmd),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .status    (status),
    .gcd_value (gcd_value)
  );

  // checks
  `BGCD_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `BGCD_ASSERT_IMP(a_sub_on_odd, cmd.sub_step, status.x_lsb && status.y_lsb)
  `BGCD_ASSERT_IMP(a_store_when_done, cmd.store_result, status.x_zero || status.y_zero)
  `BGCD_ASSERT_NEXT(a_store_sets_valid, cmd.store_result, out_valid)

endmodule

>>> tb/tb_binary_gcd_unit.sv
// self-checking testbench for binary_gcd_unit: directed table then random operand pairs
// depends on bgcd_pkg and the binary_gcd_unit rtl; randomized gaps on both channels
// every result is checked against a local stein gcd predictor or a typed-in value
module tb_binary_gcd_unit;

  localparam int W            = bgcd_pkg::DATA_WIDTH;
  localparam int N_DIRECTED   = 18;
  localparam int N_RANDOM     = 1150;
  localparam int BLOCK_ITEMS  = 50;
  localparam int DRAIN_EVERY  = 250;
  localparam int TAIL_CYCLES  = 250;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int MAX_REPORTS  = 50;
  localparam int MAX_GAP      = 18;

  typedef logic [W-1:0] word_t;

  typedef struct {
    word_t a;
    word_t b;
    bit    pinned;
    word_t gcd;
  } gcd_case_t;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  word_t operand_a;
  word_t operand_b;
  logic  out_valid;
  logic  out_ready;
  word_t gcd_value;

  word_t       gcd_expected [$];
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned pairs_sent;
  int unsigned zero_pairs_sent;
  bit          in_calm;
  bit          out_calm;

  // directed stimulus; pinned rows carry a result that is obvious by inspection
  gcd_case_t directed_cases [N_DIRECTED] = '{
    '{64'h0, 64'h0, 1'b1, 64'h0},
    '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{64'h0, 64'h1, 1'b1, 64'h1},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h1},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 1'b1, 64'h1},
    '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0000},
    '{64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b1, 64'h4000_0000_0000_0000},
    '{64'h1, 64'h8000_0000_0000_0000, 1'b1, 64'h1},
    '{64'h5, 64'h5, 1'b1, 64'h5},
    '{64'd12, 64'd18, 1'b0, 64'h0},
    '{64'd7540113804746346429, 64'd12200160415121876738, 1'b0, 64'h0},
    '{64'h1FFF_FFFF_FFFF_FFFF, 64'h0000_0000_7FFF_FFFF, 1'b0, 64'h0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 1'b0, 64'h0},
    '{64'hC000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b0, 64'h0},
    '{64'h0000_0001_0000_0000, 64'h3, 1'b0, 64'h0}
  };

  binary_gcd_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gcd_value (gcd_value)
  );

  // clock, period 4
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // stein gcd: strip shared twos, make x odd, then subtract the smaller odd value
  function automatic word_t stein_gcd(input word_t a, input word_t b);
    word_t x;
    word_t y;
    word_t smaller;
    int    shared_twos;
    x = a;
    y = b;
    shared_twos = 0;
    if (x == '0) return y;
    if (y == '0) return x;
    while (!x[0] && !y[0]) begin
      x >>= 1;
      y >>= 1;
      shared_twos++;
    end
    while (!x[0]) x >>= 1;
    do begin
      while (!y[0]) y >>= 1;
      if (x > y) begin
        smaller = y;
        y = x - y;
        x = smaller;
      end else begin
        y = y - x;
      end
    end while (y != '0);
    return x << shared_twos;
  endfunction

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("tb: mismatch, %s at cycle %0d: got %h, want %h",
               what, cycle_count, got, want);
  endtask

  // drive one operand beat and record what it should produce once taken
  task automatic send_pair(input word_t a, input word_t b, input bit pinned,
                           input word_t pinned_gcd);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (!in_ready);
    gcd_expected.push_back(pinned ? pinned_gcd : stein_gcd(a, b));
    pairs_sent++;
    if (a == '0 || b == '0) zero_pairs_sent++;
  endtask

  // hold off the sender until every pending result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (gcd_expected.size() != 0) @(negedge clk);
  endtask

  // operand pairs shaped to hit shared twos, common factors, zeros and long loops
  task automatic make_pair(output word_t a, output word_t b);
    word_t       factor;
    int unsigned shift;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        a = rand_word();
        b = rand_word();
      end
      4: begin
        factor = word_t'($urandom_range(1, 1 << 20));
        shift  = $urandom_range(0, 11);
        a = (factor * word_t'($urandom)) << shift;
        b = (factor * word_t'($urandom)) << shift;
      end
      5: begin
        a = rand_word() << $urandom_range(0, W - 1);
        b = rand_word() << $urandom_range(0, W - 1);
      end
      6: begin
        a = rand_word() >> $urandom_range(0, W - 1);
        b = '0;
        if ($urandom_range(0, 3) == 0) a = '0;
        if ($urandom_range(0, 1) == 1) begin
          b = a;
          a = '0;
        end
      end
      7: begin
        a = word_t'($urandom_range(0, 255));
        b = word_t'($urandom_range(0, 255));
      end
      8: begin
        a = rand_word();
        b = a >> $urandom_range(0, 8);
      end
      default: begin
        a = rand_word() >> $urandom_range(0, W - 1);
        b = rand_word() >> $urandom_range(0, W - 1);
      end
    endcase
  endtask

  // result receiver with random back-pressure
  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      stall = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result checker and run limit
  always @(posedge clk) begin : result_check
    word_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      if (gcd_expected.size() == 0) begin
        report_mismatch("result beat with nothing pending", gcd_value, '0);
      end else begin
        want = gcd_expected.pop_front();
        results_checked++;
        if (gcd_value !== want) report_mismatch("gcd_value", gcd_value, want);
      end
    end
  end

  // main sequence
  initial begin : stimulus
    word_t a;
    word_t b;
    rst       = 1'b1;
    in_valid  = 1'b0;
    operand_a = '0;
    operand_b = '0;
    in_calm   = 1'b0;
    out_calm  = 1'b0;
    cycle_count     = 0;
    mismatch_count  = 0;
    results_checked = 0;
    pairs_sent      = 0;
    zero_pairs_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_DIRECTED; i++)
      send_pair(directed_cases[i].a, directed_cases[i].b,
                directed_cases[i].pinned, directed_cases[i].gcd);
    wait_drained();

    // random pairs, idle pattern changes per block
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % BLOCK_ITEMS == 0) begin
        case ($urandom_range(0, 3))
          0: begin in_calm = 1'b0; out_calm = 1'b0; end
          1: begin in_calm = 1'b1; out_calm = 1'b1; end
          2: begin in_calm = 1'b1; out_calm = 1'b0; end
          default: begin in_calm = 1'b0; out_calm = 1'b1; end
        endcase
      end
      if (i > 0 && i % DRAIN_EVERY == 0) wait_drained();
      make_pair(a, b);
      send_pair(a, b, 1'b0, '0);
    end

    // drain and let any stray beat show up
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("tb: %0d operand pairs sent (%0d with a zero operand), %0d gcd results checked",
             pairs_sent, zero_pairs_sent, results_checked);
    $display("tb: %0d mismatches, %0d results still pending, %0d cycles",
             mismatch_count, gcd_expected.size(), cycle_count);
    if (mismatch_count == 0 && gcd_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> binary_gcd_unit.f
+incdir+rtl/core
rtl/core/bgcd_pkg.sv
rtl/core/bgcd_dpath.sv
rtl/core/bgcd_ctrl.sv
rtl/core/binary_gcd_unit.sv
tb/tb_binary_gcd_unit.sv
